@@ rtl/pir_pkg.sv @@
// ----------------------------------------------------------------------------
// pir_pkg
// Types, codes and helpers shared by the integer parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pir_pkg;

	localparam int MAX_LENGTH = 4096;
	localparam int CAP_INT    = (MAX_LENGTH - 1 > 4095) ? 4095 : MAX_LENGTH - 1;
	localparam logic [11:0] COUNT_CAP = 12'(CAP_INT);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_LEAD   = 3'd1;
	localparam logic [2:0] PH_SIGNED = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_PREFIX = 3'd4;
	localparam logic [2:0] PH_DIGITS = 3'd5;

	localparam logic REG_RADIX  = 1'b0;
	localparam logic REG_SIGNED = 1'b1;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;

	localparam logic [5:0] BASE_8  = 6'd8;
	localparam logic [5:0] BASE_10 = 6'd10;
	localparam logic [5:0] BASE_16 = 6'd16;

	typedef struct packed {
		logic [5:0] radix;
		logic       signed_mode;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [63:0] acc;
		logic [11:0] count;
		logic        minus;
		logic [5:0]  base;
	} state_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] value;
		logic [11:0] offset;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} digit_t;

	function automatic digit_t digit_of(input logic [7:0] c);
		digit_t d;
		d.ok    = 1'b1;
		d.value = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d.value = 4'(c - CH_ZERO);
		end else if (c >= CH_LO_A && c <= CH_LO_F) begin
			d.value = 4'(c - CH_LO_A + 8'd10);
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			d.value = 4'(c - CH_UP_A + 8'd10);
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

@@ rtl/pir_cfg.sv @@
// ----------------------------------------------------------------------------
// pir_cfg
// Configuration registers: radix and signed mode.
// ----------------------------------------------------------------------------
`default_nettype none

module pir_cfg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [5:0] cfg_data,
	output pir_pkg::cfg_t   cfg
);

	logic [5:0] radix_q;
	logic       signed_q;

	assign cfg_ready       = 1'b1;
	assign cfg.radix       = radix_q;
	assign cfg.signed_mode = signed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= 6'd0;
			signed_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pir_pkg::REG_RADIX:  radix_q  <= cfg_data;
				pir_pkg::REG_SIGNED: signed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/pir_step.sv @@
// ----------------------------------------------------------------------------
// pir_step
// Next-state and result logic for one character of the string.
// ----------------------------------------------------------------------------
`default_nettype none

module pir_step (
	input  wire logic [7:0] char_code,
	input  wire logic       first_of_string,
	input  pir_pkg::cfg_t   cfg,
	input  pir_pkg::state_t cur,
	output pir_pkg::state_t nxt,
	output pir_pkg::res_t   res
);

	pir_pkg::state_t st;
	pir_pkg::digit_t dg;
	logic [11:0]     count_inc;
	logic            blank;
	logic            is_sign;
	logic            lead_phase;
	logic            auto_or_hex;
	logic [5:0]      lead_base;
	logic [5:0]      base_eff;
	logic [63:0]     acc_src;
	logic [69:0]     prod;
	logic            digit_fits;
	logic [63:0]     acc_signed;

	always_comb begin
		if (first_of_string) begin
			st.phase = pir_pkg::PH_LEAD;
			st.acc   = 64'd0;
			st.count = 12'd0;
			st.minus = 1'b0;
			st.base  = 6'd0;
		end else begin
			st = cur;
		end
	end

	assign dg          = pir_pkg::digit_of(char_code);
	assign count_inc   = (st.count < pir_pkg::COUNT_CAP) ? st.count + 12'd1 : st.count;
	assign blank       = (char_code == pir_pkg::CH_SPACE) || (char_code == pir_pkg::CH_TAB);
	assign is_sign     = (char_code == pir_pkg::CH_PLUS) || (char_code == pir_pkg::CH_MINUS);
	assign lead_phase  = (st.phase == pir_pkg::PH_LEAD) || (st.phase == pir_pkg::PH_SIGNED);
	assign auto_or_hex = (cfg.radix == 6'd0) || (cfg.radix == pir_pkg::BASE_16);

	always_comb begin
		if (cfg.radix == 6'd0) begin
			lead_base = pir_pkg::BASE_10;
		end else begin
			lead_base = cfg.radix;
		end
	end

	assign base_eff   = lead_phase ? lead_base : st.base;
	assign acc_src    = lead_phase ? 64'd0 : st.acc;
	assign prod       = acc_src * base_eff + 70'(dg.value);
	assign digit_fits = dg.ok && ({2'b00, dg.value} < base_eff);
	assign acc_signed = st.minus ? (64'd0 - st.acc) : st.acc;

	always_comb begin
		nxt        = st;
		res.valid  = 1'b0;
		res.value  = 64'd0;
		res.offset = 12'd0;
		case (st.phase)
			pir_pkg::PH_LEAD, pir_pkg::PH_SIGNED: begin
				if (blank) begin
					nxt.count = count_inc;
				end else if (st.phase == pir_pkg::PH_LEAD && cfg.signed_mode && is_sign) begin
					nxt.minus = (char_code == pir_pkg::CH_MINUS);
					nxt.count = count_inc;
					nxt.phase = pir_pkg::PH_SIGNED;
				end else if (auto_or_hex && char_code == pir_pkg::CH_ZERO) begin
					nxt.acc   = 64'd0;
					nxt.base  = (cfg.radix == 6'd0) ? pir_pkg::BASE_8 : pir_pkg::BASE_16;
					nxt.count = count_inc;
					nxt.phase = pir_pkg::PH_ZERO;
				end else if (digit_fits) begin
					nxt.acc   = prod[63:0];
					nxt.base  = base_eff;
					nxt.count = count_inc;
					nxt.phase = pir_pkg::PH_DIGITS;
				end else begin
					nxt.acc   = 64'd0;
					nxt.base  = base_eff;
					nxt.minus = 1'b0;
					nxt.phase = pir_pkg::PH_IDLE;
					res.valid = 1'b1;
				end
			end
			pir_pkg::PH_ZERO: begin
				if (char_code == pir_pkg::CH_LO_X || char_code == pir_pkg::CH_UP_X) begin
					nxt.base  = pir_pkg::BASE_16;
					nxt.count = count_inc;
					nxt.phase = pir_pkg::PH_PREFIX;
				end else if (digit_fits) begin
					nxt.acc   = prod[63:0];
					nxt.count = count_inc;
					nxt.phase = pir_pkg::PH_DIGITS;
				end else begin
					nxt.phase  = pir_pkg::PH_IDLE;
					res.valid  = 1'b1;
					res.value  = acc_signed;
					res.offset = st.count;
				end
			end
			pir_pkg::PH_PREFIX: begin
				if (dg.ok) begin
					nxt.acc   = {60'd0, dg.value};
					nxt.count = count_inc;
					nxt.phase = pir_pkg::PH_DIGITS;
				end else begin
					nxt.minus  = 1'b0;
					nxt.phase  = pir_pkg::PH_IDLE;
					res.valid  = 1'b1;
					res.offset = st.count - 12'd1;
				end
			end
			pir_pkg::PH_DIGITS: begin
				if (digit_fits) begin
					nxt.acc   = prod[63:0];
					nxt.count = count_inc;
				end else begin
					nxt.phase  = pir_pkg::PH_IDLE;
					res.valid  = 1'b1;
					res.value  = acc_signed;
					res.offset = st.count;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/parse_integer_radix_unit.sv @@
// ----------------------------------------------------------------------------
// parse_integer_radix_unit
// Streaming integer parser: one character per word, one result per number.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    char_code[7:0], first_of_string
//  out      out_valid / out_ready  parsed_value[63:0], end_offset[11:0]
//  cfg      cfg_valid / cfg_ready  cfg_index (0 radix, 1 signed_mode), cfg_data[5:0]
//
//  One character per cycle unless stalled: input register, then one pass through the
//  multiply-add by the base (64 x 6 bits) into the parser state and result register.
//  A result is registered as its terminating character leaves the input register.
//  Reset clears the configuration to radix 0, unsigned, and idles the parser.
//  A stalled result holds the input register, which takes at most one more word.
// ----------------------------------------------------------------------------
`default_nettype none

module parse_integer_radix_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        first_of_string,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      parsed_value,
	output logic [11:0]      end_offset,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [5:0]  cfg_data
);

	pir_pkg::cfg_t   cfg;
	pir_pkg::state_t state_q;
	pir_pkg::state_t state_nxt;
	pir_pkg::res_t   res;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        first_s1;
	logic        advance;
	logic        out_valid_q;
	logic [63:0] value_q;
	logic [11:0] offset_q;

	pir_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pir_step u_step (
		.char_code       (char_s1),
		.first_of_string (first_s1),
		.cfg             (cfg),
		.cur             (state_q),
		.nxt             (state_nxt),
		.res             (res)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1  <= char_code;
			first_s1 <= first_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= pir_pkg::PH_IDLE;
			state_q.acc   <= 64'd0;
			state_q.count <= 12'd0;
			state_q.minus <= 1'b0;
			state_q.base  <= 6'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			value_q  <= res.value;
			offset_q <= res.offset;
		end
	end

	assign out_valid    = out_valid_q;
	assign parsed_value = value_q;
	assign end_offset   = offset_q;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for parse_integer_radix_unit. A queue of character
// words feeds a valid/ready driver; every accepted word runs through a local
// parser model that predicts each number and its end offset. A monitor with
// random back-pressure compares every result word with the oldest prediction.
// The run covers directed corner strings, then phases of random strings
// under many radix and sign settings.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pir_pkg::*;

	localparam logic [7:0]  CH_NUL        = 8'h00;
	localparam int          NO_WEIGHT     = 99;
	localparam logic [11:0] OFFSET_LIMIT  =
		(MAX_LENGTH - 1 > 4095) ? 12'd4095 : 12'(MAX_LENGTH - 1);
	localparam int          QUIET_LIMIT   = 2000;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          TAIL_CYCLES   = 8;
	localparam int          RANDOM_PHASES = 12;
	localparam int          PHASE_ITEMS   = 120;
	localparam int          MAX_REPORTS   = 50;

	typedef struct packed {
		logic [7:0] code;
		logic       first;
	} char_word_t;

	typedef struct packed {
		logic [63:0] value;
		logic [11:0] offset;
	} number_t;

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        in_valid        = 1'b0;
	logic        in_ready;
	logic [7:0]  char_code       = 8'h00;
	logic        first_of_string = 1'b0;
	logic        out_valid;
	logic        out_ready       = 1'b0;
	logic [63:0] parsed_value;
	logic [11:0] end_offset;
	logic        cfg_valid       = 1'b0;
	logic        cfg_ready;
	logic        cfg_index       = 1'b0;
	logic [5:0]  cfg_data        = 6'd0;

	char_word_t pending[$];
	number_t    expected_numbers[$];
	char_word_t next_word;
	number_t    want;

	// parser shadow: configuration and state
	logic [5:0]  cfg_radix  = 6'd0;
	logic        cfg_signed = 1'b0;
	logic [2:0]  ps_phase   = PH_IDLE;
	logic [63:0] ps_acc     = 64'd0;
	logic [11:0] ps_count   = 12'd0;
	logic        ps_minus   = 1'b0;
	logic [5:0]  ps_base    = 6'd0;

	int  queued_total    = 0;
	int  words_taken     = 0;
	int  numbers_checked = 0;
	int  writes_done     = 0;
	int  errors          = 0;
	int  gap_left        = 0;
	int  stall_left      = 0;
	int  quiet_cycles    = 0;
	bit  calm            = 1'b0;

	parse_integer_radix_unit DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.char_code       (char_code),
		.first_of_string (first_of_string),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.parsed_value    (parsed_value),
		.end_offset      (end_offset),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic note_error(input string msg);
		errors++;
		if (errors <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
	endtask

	function automatic int char_weight(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
		if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
		return NO_WEIGHT;
	endfunction

	task automatic count_char();
		if (ps_count < OFFSET_LIMIT) ps_count++;
	endtask

	task automatic emit_number(input logic [63:0] value, input logic [11:0] offset);
		number_t n;
		n.value  = ps_minus ? 64'd0 - value : value;
		n.offset = offset;
		expected_numbers.push_back(n);
		ps_phase = PH_IDLE;
	endtask

	task automatic take_digit_or_close(input int w, input bit have_digits);
		if (w < int'(ps_base)) begin
			ps_acc = ps_acc * 64'(ps_base) + 64'(w);
			count_char();
			ps_phase = PH_DIGITS;
		end else if (!have_digits) begin
			ps_minus = 1'b0;
			emit_number(64'd0, 12'd0);
		end else begin
			emit_number(ps_acc, ps_count);
		end
	endtask

	task automatic parse_char(input logic [7:0] c, input logic first);
		int w;
		w = char_weight(c);
		if (first) begin
			ps_phase = PH_LEAD;
			ps_acc   = 64'd0;
			ps_count = 12'd0;
			ps_minus = 1'b0;
			ps_base  = 6'd0;
		end
		case (ps_phase)
			PH_LEAD, PH_SIGNED: begin
				if (c == CH_SPACE || c == CH_TAB) begin
					count_char();
				end else if (ps_phase == PH_LEAD && cfg_signed &&
						(c == CH_PLUS || c == CH_MINUS)) begin
					ps_minus = (c == CH_MINUS);
					count_char();
					ps_phase = PH_SIGNED;
				end else begin
					ps_acc = 64'd0;
					if ((cfg_radix == 6'd0 || cfg_radix == BASE_16) && c == CH_ZERO) begin
						ps_base = (cfg_radix == 6'd0) ? BASE_8 : BASE_16;
						count_char();
						ps_phase = PH_ZERO;
					end else begin
						ps_base = (cfg_radix == 6'd0) ? BASE_10 : cfg_radix;
						take_digit_or_close(w, 1'b0);
					end
				end
			end
			PH_ZERO: begin
				if (c == CH_LO_X || c == CH_UP_X) begin
					ps_base = BASE_16;
					count_char();
					ps_phase = PH_PREFIX;
				end else begin
					take_digit_or_close(w, 1'b1);
				end
			end
			PH_PREFIX: begin
				if (w != NO_WEIGHT) begin
					ps_acc = 64'(w);
					count_char();
					ps_phase = PH_DIGITS;
				end else begin
					ps_minus = 1'b0;
					emit_number(64'd0, ps_count - 12'd1);
				end
			end
			PH_DIGITS: take_digit_or_close(w, 1'b1);
			default: ;
		endcase
	endtask

	// driver: present queued words, idle in short bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid        <= 1'b0;
			char_code       <= 8'h00;
			first_of_string <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				parse_char(char_code, first_of_string);
				words_taken++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					next_word = pending.pop_front();
					in_valid        <= 1'b1;
					char_code       <= next_word.code;
					first_of_string <= next_word.first;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure, compare each result word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_numbers.size() == 0) begin
					note_error($sformatf("result with none pending: value %h offset %0d",
						parsed_value, end_offset));
				end else begin
					want = expected_numbers.pop_front();
					numbers_checked++;
					if (parsed_value !== want.value)
						note_error($sformatf("parsed_value expected %h, got %h",
							want.value, parsed_value));
					if (end_offset !== want.offset)
						note_error($sformatf("end_offset expected %0d, got %0d",
							want.offset, end_offset));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_ready) && !(out_valid && out_ready) &&
				!(cfg_valid && cfg_ready))
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic put_char(input logic [7:0] c, input logic first);
		char_word_t w;
		w.code  = c;
		w.first = first;
		pending.push_back(w);
		queued_total++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) put_char(s[i], i == 0);
	endtask

	task automatic drain();
		while (words_taken != queued_total || expected_numbers.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [5:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_RADIX) cfg_radix = data;
		else cfg_signed = data[0];
		writes_done++;
	endtask

	task automatic next_mode(input logic [5:0] rdx, input logic sgn);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_RADIX, rdx);
		write_reg(REG_SIGNED, {5'd0, sgn});
	endtask

	task automatic queue_number(input logic [5:0] rdx, input logic sgn);
		logic [7:0] text[$];
		int eff;
		int n;
		int w;
		repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0)
			text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
		if ($urandom_range(0, sgn ? 2 : 12) == 0) begin
			text.push_back($urandom_range(0, 2) ? CH_MINUS : CH_PLUS);
			if ($urandom_range(0, 3) == 0) text.push_back(CH_SPACE);
		end
		eff = (rdx == 6'd0) ? 10 : (rdx > BASE_16 ? 16 : int'(rdx));
		if (rdx == 6'd0 || rdx == BASE_16) begin
			case ($urandom_range(0, 3))
				0: begin
					text.push_back(CH_ZERO);
					text.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
					eff = 16;
				end
				1: begin
					if (rdx == 6'd0) begin
						text.push_back(CH_ZERO);
						eff = 8;
					end
				end
				default: ;
			endcase
		end
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 8);
		repeat (n) begin
			w = $urandom_range(0, eff - 1);
			if (w < 10) text.push_back(CH_ZERO + 8'(w));
			else text.push_back(($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(w - 10));
		end
		text.push_back($urandom_range(0, 1) ? CH_NUL : 8'($urandom_range(0, 255)));
		foreach (text[i]) put_char(text[i], i == 0);
	endtask

	task automatic queue_noise();
		string specials;
		specials = "  \t+-0xX19aFgz";
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 1))
				put_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			else
				put_char(specials[$urandom_range(0, specials.len() - 1)],
					$urandom_range(0, 3) == 0);
		end
	endtask

	initial begin
		logic [5:0] rdx;
		logic       sgn;
		int         phase_start;
		bit         paused;
		logic [5:0] radix_plan[8];
		radix_plan = '{6'd0, BASE_16, 6'd36, 6'd1, BASE_10, BASE_8, 6'd2, 6'd17};
		paused = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		next_mode(6'd0, 1'b1);
		put_char(CH_NUL, 1'b1);
		put_text("\t- 0xFfg");
		put_text("0X");
		put_char(CH_NUL, 1'b0);
		put_text("+0779");
		put_char("A", 1'b0);
		put_text("12");
		put_text("5");
		put_char(CH_NUL, 1'b0);

		next_mode(6'd36, 1'b0);
		put_text("-5");
		put_text("fz");

		next_mode(6'd1, 1'b0);
		put_text("001");

		next_mode(BASE_16, 1'b1);
		put_text("-0xa");
		put_char(CH_NUL, 1'b0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 8) begin
				rdx = radix_plan[p];
				sgn = p[0];
			end else begin
				if ($urandom_range(0, 2) == 0) rdx = $urandom_range(0, 1) ? BASE_16 : 6'd0;
				else rdx = $urandom_range(0, 36);
				sgn = $urandom_range(0, 1);
			end
			next_mode(rdx, sgn);
			if (p >= RANDOM_PHASES - 2) calm = 1'b1;
			phase_start = queued_total;
			while (queued_total - phase_start < PHASE_ITEMS) begin
				// hold the sender until every number is back
				if (p == 2 && !paused && queued_total - phase_start >= PHASE_ITEMS / 2) begin
					drain();
					paused = 1'b1;
				end
				if ($urandom_range(0, 7) == 0) queue_noise();
				else queue_number(rdx, sgn);
			end
			put_char(CH_NUL, 1'b1);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_numbers.size() != 0)
			note_error($sformatf("%0d expected numbers never arrived",
				expected_numbers.size()));
		$display("Streamed %0d characters and checked %0d numbers across %0d register writes,",
			words_taken, numbers_checked, writes_done);
		$display("covering radix 0 to 36, both sign modes, hex prefixes and restarts.");
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
